// ===== src/beg_pkg.sv =====
`default_nettype none

package beg_pkg;

   // Defaults for the top-level parameters
   localparam int COS_TABLE_DEPTH_DEF = 256;
   localparam int TIME_WIDTH_DEF      = 48;

   // Field widths
   localparam int LEN_WIDTH   = 24;               // one phase length in us
   localparam int CYCLE_WIDTH = LEN_WIDTH + 1;    // inhale plus exhale
   localparam int FRAC_WIDTH  = 16;               // Q0.16 fraction
   localparam int AMP_WIDTH   = 17;               // Q0.16 with room for 1.0
   localparam int BEAT_WIDTH  = 15;
   localparam int REQ_BEAT_WIDTH = 16;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [AMP_WIDTH-1:0] ONE_Q16 = 17'h10000;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INHALE  = 2'd0,
      CSR_EXHALE  = 2'd1,
      CSR_FLOOR   = 2'd2,
      CSR_BEAT    = 2'd3
   } csr_index_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [LEN_WIDTH-1:0]  inhale_length_us;
      logic [LEN_WIDTH-1:0]  exhale_length_us;
      logic [AMP_WIDTH-1:0]  amplitude_floor;
      logic [BEAT_WIDTH-1:0] default_beat;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      inhale_length_us: 24'd1618034,
      exhale_length_us: 24'd2618034,
      amplitude_floor:  17'd19661,
      default_beat:     15'd1536
   };

endpackage

`default_nettype wire

// ===== src/beg_front.sv =====
`default_nettype none

module beg_front import beg_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                         req_valid,
   input  wire logic signed [TIME_WIDTH-1:0] req_time_us,
   input  wire logic signed [REQ_BEAT_WIDTH-1:0] req_beat_request,
   output logic                              req_stall,
   input  wire cfg_type                      cfg,
   input  wire logic                         queue_full,
   output logic                              push,
   output logic [TIME_WIDTH-1:0]             push_mag,
   output logic                              push_neg,
   output logic [BEAT_WIDTH-1:0]             push_beat
);

   logic beat_positive;

   // Hold off the requester while the queue is full
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Split time into sign and magnitude; the most negative value fits unsigned
   assign push_neg = req_time_us[TIME_WIDTH-1];
   assign push_mag = push_neg ? TIME_WIDTH'(~req_time_us + 1'b1) : req_time_us;

   // Non-positive beat requests take the default
   assign beat_positive = (req_beat_request != '0) && !req_beat_request[REQ_BEAT_WIDTH-1];
   assign push_beat     = beat_positive ? req_beat_request[BEAT_WIDTH-1:0] : cfg.default_beat;

endmodule

`default_nettype wire

// ===== src/beg_queue.sv =====
`default_nettype none

module beg_queue import beg_pkg::*; #(
   parameter int DATA_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       full,
   input  wire logic                  pop_ready,
   output logic                       pop_valid,
   output logic [DATA_WIDTH-1:0]      pop_data
);

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  pop;

   assign full      = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/beg_back.sv =====
`default_nettype none

module beg_back import beg_pkg::*; #(
   parameter int TIME_WIDTH      = TIME_WIDTH_DEF,
   parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  in_valid,
   input  wire logic [TIME_WIDTH-1:0] in_mag,
   input  wire logic                  in_neg,
   input  wire logic [BEAT_WIDTH-1:0] in_beat,
   output logic                       in_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_exhaling,
   output logic [FRAC_WIDTH-1:0]      rsp_phase_progress,
   output logic [AMP_WIDTH-1:0]       rsp_amplitude,
   output logic [BEAT_WIDTH-1:0]      rsp_beat_offset
);

   localparam int IDX_WIDTH  = $clog2(COS_TABLE_DEPTH);
   localparam int S_WIDTH    = FRAC_WIDTH + IDX_WIDTH;
   localparam int PROD_WIDTH = 2 * AMP_WIDTH;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint unsigned TAYLOR_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

   typedef logic [AMP_WIDTH-1:0] rom_type [COS_TABLE_DEPTH+1];

   // Half-cosine table (1 - cos(pi*i/D))/2 in Q0.16, built at elaboration
   function automatic rom_type build_rom();
      rom_type          t;
      longint unsigned  x, x2, mag, c, j;
      longint           sum;
      for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
         j   = (2 * i <= COS_TABLE_DEPTH) ? longint'(i) : longint'(COS_TABLE_DEPTH - i);
         x   = (PI_Q30 * j) / COS_TABLE_DEPTH;
         x2  = (x * x) >> 30;
         mag = 64'd1 << 30;
         sum = longint'(mag);
         for (int k = 0; k < 8; k++) begin
            mag = ((mag * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 0) begin
               sum = sum - longint'(mag);
            end else begin
               sum = sum + longint'(mag);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         c = (longint'(sum) + 64'd16384) >> 15;
         if (c > 64'd32768) begin
            c = 64'd32768;
         end
         t[i] = (2 * i <= COS_TABLE_DEPTH) ? AMP_WIDTH'(64'd32768 - c)
                                           : AMP_WIDTH'(64'd32768 + c);
      end
      return t;
   endfunction

   localparam rom_type ROM = build_rom();

   logic                   advance;
   logic [CYCLE_WIDTH-1:0] cycle;
   logic [AMP_WIDTH-1:0]   flr;
   logic [AMP_WIDTH-1:0]   span;

   // Whole pipeline moves when the output register can take a result
   assign advance  = !rsp_valid || !rsp_stall;
   assign in_ready = advance;
   assign cycle    = {1'b0, cfg.inhale_length_us} + {1'b0, cfg.exhale_length_us};
   assign flr      = (cfg.amplitude_floor > ONE_Q16) ? ONE_Q16 : cfg.amplitude_floor;
   assign span     = ONE_Q16 - flr;

   // ---------------- modulo: one dividend bit per stage ----------------
   logic                   mod_valid_ff [TIME_WIDTH];
   logic [CYCLE_WIDTH-1:0] mod_rem_ff   [TIME_WIDTH];
   logic [TIME_WIDTH-1:0]  mod_num_ff   [TIME_WIDTH];
   logic                   mod_neg_ff   [TIME_WIDTH];
   logic [BEAT_WIDTH-1:0]  mod_beat_ff  [TIME_WIDTH];

   for (genvar k = 0; k < TIME_WIDTH; k++) begin : g_mod
      logic                   prev_valid;
      logic [CYCLE_WIDTH-1:0] prev_rem;
      logic [TIME_WIDTH-1:0]  prev_num;
      logic                   prev_neg;
      logic [BEAT_WIDTH-1:0]  prev_beat;
      logic [CYCLE_WIDTH:0]   shifted;
      logic [CYCLE_WIDTH-1:0] rem_in;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_num   = in_mag;
         assign prev_neg   = in_neg;
         assign prev_beat  = in_beat;
      end else begin : g_next
         assign prev_valid = mod_valid_ff[k-1];
         assign prev_rem   = mod_rem_ff[k-1];
         assign prev_num   = mod_num_ff[k-1];
         assign prev_neg   = mod_neg_ff[k-1];
         assign prev_beat  = mod_beat_ff[k-1];
      end

      // Restoring remainder step
      assign shifted = {prev_rem, prev_num[TIME_WIDTH-1-k]};
      assign rem_in  = (shifted >= {1'b0, cycle}) ? CYCLE_WIDTH'(shifted - {1'b0, cycle})
                                                  : shifted[CYCLE_WIDTH-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            mod_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            mod_valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            mod_rem_ff[k]  <= rem_in;
            mod_num_ff[k]  <= prev_num;
            mod_neg_ff[k]  <= prev_neg;
            mod_beat_ff[k] <= prev_beat;
         end
      end
   end

   // ---------------- wrap negative times and pick the phase ----------------
   logic                   wrap_valid_ff;
   logic [LEN_WIDTH-1:0]   wrap_pos_ff, wrap_pos_in;
   logic                   wrap_exh_ff, wrap_exh_in;
   logic [BEAT_WIDTH-1:0]  wrap_beat_ff;
   logic [CYCLE_WIDTH-1:0] rem_last, pos;

   assign rem_last = mod_rem_ff[TIME_WIDTH-1];

   always_comb begin
      if (cycle == '0) begin
         pos = '0;
      end else if (mod_neg_ff[TIME_WIDTH-1] && (rem_last != '0)) begin
         pos = cycle - rem_last;
      end else begin
         pos = rem_last;
      end
      wrap_exh_in = (pos >= {1'b0, cfg.inhale_length_us});
      wrap_pos_in = wrap_exh_in ? LEN_WIDTH'(pos - {1'b0, cfg.inhale_length_us})
                                : pos[LEN_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
      end else if (advance) begin
         wrap_valid_ff <= mod_valid_ff[TIME_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wrap_pos_ff  <= wrap_pos_in;
         wrap_exh_ff  <= wrap_exh_in;
         wrap_beat_ff <= mod_beat_ff[TIME_WIDTH-1];
      end
   end

   // ---------------- progress divide: one quotient bit per stage ----------------
   logic                  div_valid_ff [FRAC_WIDTH];
   logic [LEN_WIDTH-1:0]  div_rem_ff   [FRAC_WIDTH];
   logic [FRAC_WIDTH-1:0] div_quo_ff   [FRAC_WIDTH];
   logic                  div_exh_ff   [FRAC_WIDTH];
   logic [BEAT_WIDTH-1:0] div_beat_ff  [FRAC_WIDTH];

   for (genvar k = 0; k < FRAC_WIDTH; k++) begin : g_div
      logic                  prev_valid;
      logic [LEN_WIDTH-1:0]  prev_rem;
      logic [FRAC_WIDTH-1:0] prev_quo;
      logic                  prev_exh;
      logic [BEAT_WIDTH-1:0] prev_beat;
      logic [LEN_WIDTH-1:0]  len;
      logic [LEN_WIDTH:0]    shifted;
      logic                  ge;
      logic [LEN_WIDTH-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign prev_valid = wrap_valid_ff;
         assign prev_rem   = wrap_pos_ff;
         assign prev_quo   = '0;
         assign prev_exh   = wrap_exh_ff;
         assign prev_beat  = wrap_beat_ff;
      end else begin : g_next
         assign prev_valid = div_valid_ff[k-1];
         assign prev_rem   = div_rem_ff[k-1];
         assign prev_quo   = div_quo_ff[k-1];
         assign prev_exh   = div_exh_ff[k-1];
         assign prev_beat  = div_beat_ff[k-1];
      end

      assign len     = prev_exh ? cfg.exhale_length_us : cfg.inhale_length_us;
      assign shifted = {prev_rem, 1'b0};
      assign ge      = (shifted >= {1'b0, len});
      assign rem_in  = ge ? LEN_WIDTH'(shifted - {1'b0, len}) : shifted[LEN_WIDTH-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            div_valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_rem_ff[k]  <= rem_in;
            div_quo_ff[k]  <= {prev_quo[FRAC_WIDTH-2:0], ge};
            div_exh_ff[k]  <= prev_exh;
            div_beat_ff[k] <= prev_beat;
         end
      end
   end

   // ---------------- table position ----------------
   localparam int DL = FRAC_WIDTH - 1;

   logic                  tab_valid_ff;
   logic [FRAC_WIDTH-1:0] tab_prog_ff, tab_prog_in;
   logic [S_WIDTH-1:0]    tab_s_ff, tab_s_in;
   logic                  tab_exh_ff;
   logic [BEAT_WIDTH-1:0] tab_beat_ff;
   logic [LEN_WIDTH-1:0]  last_len;

   // A zero-length phase reports no progress
   assign last_len    = div_exh_ff[DL] ? cfg.exhale_length_us : cfg.inhale_length_us;
   assign tab_prog_in = (last_len == '0) ? '0 : div_quo_ff[DL];
   assign tab_s_in    = S_WIDTH'(tab_prog_in) * S_WIDTH'(COS_TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_valid_ff <= 1'b0;
      end else if (advance) begin
         tab_valid_ff <= div_valid_ff[DL];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tab_prog_ff <= tab_prog_in;
         tab_s_ff    <= tab_s_in;
         tab_exh_ff  <= div_exh_ff[DL];
         tab_beat_ff <= div_beat_ff[DL];
      end
   end

   // ---------------- table lookup and interpolation products ----------------
   logic                  mul_valid_ff;
   logic [PROD_WIDTH-1:0] mul_p0_ff, mul_p0_in, mul_p1_ff, mul_p1_in;
   logic [FRAC_WIDTH-1:0] mul_prog_ff;
   logic                  mul_exh_ff;
   logic [BEAT_WIDTH-1:0] mul_beat_ff;
   logic [IDX_WIDTH:0]    idx0, idx1;
   logic [FRAC_WIDTH-1:0] frac;
   logic [AMP_WIDTH-1:0]  w0, w1;

   assign idx0 = {1'b0, tab_s_ff[S_WIDTH-1:FRAC_WIDTH]};
   assign idx1 = idx0 + 1'b1;
   assign frac = tab_s_ff[FRAC_WIDTH-1:0];
   assign w0   = ROM[idx0];
   assign w1   = ROM[idx1];
   assign mul_p0_in = PROD_WIDTH'(w0) * PROD_WIDTH'(ONE_Q16 - {1'b0, frac});
   assign mul_p1_in = PROD_WIDTH'(w1) * PROD_WIDTH'(frac);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= tab_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_p0_ff   <= mul_p0_in;
         mul_p1_ff   <= mul_p1_in;
         mul_prog_ff <= tab_prog_ff;
         mul_exh_ff  <= tab_exh_ff;
         mul_beat_ff <= tab_beat_ff;
      end
   end

   // ---------------- scale by the floor-to-one span ----------------
   logic                  amp_valid_ff;
   logic [PROD_WIDTH-1:0] amp_prod_ff, amp_prod_in;
   logic [FRAC_WIDTH-1:0] amp_prog_ff;
   logic                  amp_exh_ff;
   logic [BEAT_WIDTH-1:0] amp_beat_ff;
   logic [PROD_WIDTH:0]   gsum;
   logic [AMP_WIDTH-1:0]  g;

   assign gsum        = {1'b0, mul_p0_ff} + {1'b0, mul_p1_ff};
   assign g           = gsum[FRAC_WIDTH +: AMP_WIDTH];
   assign amp_prod_in = PROD_WIDTH'(span) * PROD_WIDTH'(g);

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_valid_ff <= 1'b0;
      end else if (advance) begin
         amp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         amp_prod_ff <= amp_prod_in;
         amp_prog_ff <= mul_prog_ff;
         amp_exh_ff  <= mul_exh_ff;
         amp_beat_ff <= mul_beat_ff;
      end
   end

   // ---------------- round and register the result ----------------
   logic                  rsp_valid_ff;
   logic                  rsp_exhaling_ff;
   logic [FRAC_WIDTH-1:0] rsp_phase_progress_ff;
   logic [AMP_WIDTH-1:0]  rsp_amplitude_ff, rsp_amplitude_in;
   logic [BEAT_WIDTH-1:0] rsp_beat_offset_ff;
   logic [PROD_WIDTH-1:0] rounded;
   logic [AMP_WIDTH-1:0]  r;

   assign rounded          = amp_prod_ff + PROD_WIDTH'(32768);
   assign r                = rounded[FRAC_WIDTH +: AMP_WIDTH];
   assign rsp_amplitude_in = amp_exh_ff ? (ONE_Q16 - r) : (flr + r);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= amp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_exhaling_ff       <= amp_exh_ff;
         rsp_phase_progress_ff <= amp_prog_ff;
         rsp_amplitude_ff      <= rsp_amplitude_in;
         rsp_beat_offset_ff    <= amp_beat_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_exhaling       = rsp_exhaling_ff;
   assign rsp_phase_progress = rsp_phase_progress_ff;
   assign rsp_amplitude      = rsp_amplitude_ff;
   assign rsp_beat_offset    = rsp_beat_offset_ff;

   // ---------------- checks ----------------
   a_amp_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_amplitude_ff <= ONE_Q16))
      else $error("amplitude above one");

   a_inhale_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_exhaling_ff) |-> (rsp_amplitude_ff >= flr))
      else $error("inhale amplitude below floor");

   a_exhale_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exhaling_ff && (rsp_phase_progress_ff == '0))
      |-> (rsp_amplitude_ff == ONE_Q16))
      else $error("exhale does not start at full amplitude");

   a_inhale_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_exhaling_ff && (rsp_phase_progress_ff == '0))
      |-> (rsp_amplitude_ff == flr))
      else $error("inhale does not start at floor");

endmodule

`default_nettype wire

// ===== src/breathing_envelope_generator.sv =====
`default_nettype none

// Breathing envelope generator. Each request carries a signed time in
// microseconds and a requested beat in Q8.8 Hz; each gives one response
// with the breath phase, the Q0.16 progress within it, a raised-cosine
// amplitude in Q0.16 and the beat in use. One request is taken per clock
// while the queue is not full. A request passes through the queue slot,
// the bit-per-stage modulo pipeline (TIME_WIDTH stages), the wrap stage,
// the bit-per-stage progress divider (16 stages) and the table and scaling
// stages. A four-entry queue separates request intake from the pipeline,
// which holds as a whole while the response side stalls. Registers may
// only be written while no request is in flight.
module breathing_envelope_generator import beg_pkg::*; #(
   parameter int TIME_WIDTH      = TIME_WIDTH_DEF,
   parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [TIME_WIDTH-1:0]     req_time_us,
   input  wire logic signed [REQ_BEAT_WIDTH-1:0] req_beat_request,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_exhaling,
   output logic [FRAC_WIDTH-1:0]                 rsp_phase_progress,
   output logic [AMP_WIDTH-1:0]                  rsp_amplitude,
   output logic [BEAT_WIDTH-1:0]                 rsp_beat_offset,
   input  wire logic                             csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]        csr_data
);

   localparam int Q_WIDTH = TIME_WIDTH + 1 + BEAT_WIDTH;

   cfg_type               cfg_ff;
   logic                  queue_full, push, push_neg, pop_valid, pop_ready;
   logic [TIME_WIDTH-1:0] push_mag;
   logic [BEAT_WIDTH-1:0] push_beat;
   logic [Q_WIDTH-1:0]    pop_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_INHALE: cfg_ff.inhale_length_us <= csr_data[LEN_WIDTH-1:0];
            CSR_EXHALE: cfg_ff.exhale_length_us <= csr_data[LEN_WIDTH-1:0];
            CSR_FLOOR:  cfg_ff.amplitude_floor  <= csr_data[AMP_WIDTH-1:0];
            CSR_BEAT:   cfg_ff.default_beat     <= csr_data[BEAT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   beg_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .req_valid        (req_valid),
      .req_time_us      (req_time_us),
      .req_beat_request (req_beat_request),
      .req_stall        (req_stall),
      .cfg              (cfg_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_mag         (push_mag),
      .push_neg         (push_neg),
      .push_beat        (push_beat)
   );

   beg_queue #(
      .DATA_WIDTH (Q_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_mag, push_neg, push_beat}),
      .full      (queue_full),
      .pop_ready (pop_ready),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   beg_back #(
      .TIME_WIDTH      (TIME_WIDTH),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (pop_valid),
      .in_mag             (pop_data[Q_WIDTH-1 -: TIME_WIDTH]),
      .in_neg             (pop_data[BEAT_WIDTH]),
      .in_beat            (pop_data[BEAT_WIDTH-1:0]),
      .in_ready           (pop_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_exhaling       (rsp_exhaling),
      .rsp_phase_progress (rsp_phase_progress),
      .rsp_amplitude      (rsp_amplitude),
      .rsp_beat_offset    (rsp_beat_offset)
   );

endmodule

`default_nettype wire
